// ===== hw/rtl/lcc_pkg.sv =====
// Package for the letter contact counter: sizes, command codes, sequencer states
// and the table index helper. It depends on nothing else.
package lcc_pkg;

  localparam int ALPHABET_SIZE = 26;
  localparam int COUNT_WIDTH   = 32;
  localparam int OUT_W         = 32;
  localparam int LETTER_W      = $clog2(ALPHABET_SIZE);
  localparam int TBL_DEPTH     = ALPHABET_SIZE * ALPHABET_SIZE;
  localparam int TBL_AW        = $clog2(TBL_DEPTH);
  localparam int TOTAL_AW      = $clog2(ALPHABET_SIZE);
  localparam int WINDOW_LEN    = 3;
  localparam int CLEAR_CHECK   = 2;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CASE_OFFSET  = 8'd32;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [LETTER_W-1:0]    letter_t;
  typedef logic [TBL_AW-1:0]      tbl_addr_t;
  typedef logic [TOTAL_AW-1:0]    total_addr_t;

  typedef enum logic [1:0] {
    CMD_FEED  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_COUNT,
    S_WR_R,
    S_WR_L,
    S_WR_T,
    S_QRD,
    S_QOUT
  } state_e;

  // Flat index of a (row, column) pair in a contact table.
  function automatic tbl_addr_t tbl_index(letter_t row, letter_t col);
    tbl_index = TBL_AW'(TBL_AW'(row) * TBL_AW'(ALPHABET_SIZE)) + TBL_AW'(col);
  endfunction

endpackage

// ===== hw/rtl/letter_contact_counter.sv =====
// Top level of the letter contact counter: sequencer, window registers and the
// shared saturating incrementer. Depends on lcc_pkg and lcc_ram.
//
// Usage. The input channel carries one command per transfer: feed a text byte,
// read one table entry, or clear all counts. The output channel carries one
// result per read command and nothing for the other commands.
// A fed letter takes a count increment alone while the window is still loading;
// once it is full, the count increment is followed by one read-modify-write each
// for the right table, the left table and the letter totals. All of these go
// through one saturating incrementer, which sets the rate. A non-letter byte or
// an unused command leaves the sequencer idle. A read reaches the output register
// in steps: the address is registered, then the registered RAM read, then the load.
// A clear, and likewise the exit from reset, sweeps all 676 table rows at one
// row per cycle, so the input stalls for the whole sweep; the totals are zeroed
// for the first 26 rows of that sweep. in_stall_o is high whenever the sequencer
// is busy. The output register lets the next command be taken while a result
// still waits; a later read waits in its last step until out_stall_i frees
// the output register, and the result holds steady while it is stalled.
module letter_contact_counter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [7:0]  data_byte_i,
  input  logic [4:0]  query_letter_i,
  input  logic [4:0]  neighbor_letter_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] right_contacts_o,
  output logic [31:0] left_contacts_o,
  output logic [31:0] letter_total_o,
  output logic [31:0] letters_seen_o
);
  import lcc_pkg::*;

  state_e      state_q, state_d;
  tbl_addr_t   clr_q, clr_d;
  letter_t     earlier_q, earlier_d;
  letter_t     middle_q, middle_d;
  count_t      count_q, count_d;
  tbl_addr_t   r_addr_q, r_addr_d;
  tbl_addr_t   l_addr_q, l_addr_d;
  total_addr_t t_addr_q, t_addr_d;
  logic        pair_ok_q, pair_ok_d;
  logic        total_ok_q, total_ok_d;
  logic        out_valid_q, out_valid_d;
  logic [OUT_W-1:0] right_q, left_q, total_q, seen_q;
  logic        out_load;

  logic        accept;
  logic [7:0]  upper_byte;
  logic [7:0]  letter_offs;
  logic        is_letter;
  letter_t     new_letter;
  logic        q_ok, n_ok;

  count_t      inc_op, inc_res;
  count_t      r_rdata, l_rdata, t_rdata;
  logic        r_we, l_we, t_we;
  tbl_addr_t   r_waddr, l_waddr;
  total_addr_t t_waddr;
  count_t      r_wdata, l_wdata, t_wdata;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  // Fold lower case to upper case, then keep only letters inside the alphabet.
  always_comb begin
    if (data_byte_i >= CHAR_LOWER_A && data_byte_i <= CHAR_LOWER_Z) begin
      upper_byte = data_byte_i - CASE_OFFSET;
    end else begin
      upper_byte = data_byte_i;
    end
    letter_offs = upper_byte - CHAR_UPPER_A;
    is_letter   = (upper_byte >= CHAR_UPPER_A) && (upper_byte <= CHAR_UPPER_Z) &&
                  (32'(letter_offs) < 32'(ALPHABET_SIZE));
    new_letter  = letter_offs[LETTER_W-1:0];
  end

  assign q_ok = 32'(query_letter_i) < 32'(ALPHABET_SIZE);
  assign n_ok = 32'(neighbor_letter_i) < 32'(ALPHABET_SIZE);

  // The one shared saturating incrementer; the sequencer picks its operand.
  always_comb begin
    unique case (state_q)
      S_WR_R:  inc_op = r_rdata;
      S_WR_L:  inc_op = l_rdata;
      S_WR_T:  inc_op = t_rdata;
      default: inc_op = count_q;
    endcase
    inc_res = (inc_op == '1) ? inc_op : inc_op + count_t'(1);
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    earlier_d   = earlier_q;
    middle_d    = middle_q;
    count_d     = count_q;
    r_addr_d    = r_addr_q;
    l_addr_d    = l_addr_q;
    t_addr_d    = t_addr_q;
    pair_ok_d   = pair_ok_q;
    total_ok_d  = total_ok_q;
    out_load    = 1'b0;
    r_we        = 1'b0;
    l_we        = 1'b0;
    t_we        = 1'b0;
    r_waddr     = r_addr_q;
    l_waddr     = l_addr_q;
    t_waddr     = t_addr_q;
    r_wdata     = inc_res;
    l_wdata     = inc_res;
    t_wdata     = inc_res;

    unique case (state_q)
      S_CLEAR: begin
        r_we    = 1'b1;
        l_we    = 1'b1;
        t_we    = (32'(clr_q) < 32'(ALPHABET_SIZE));
        r_waddr = clr_q;
        l_waddr = clr_q;
        t_waddr = clr_q[TOTAL_AW-1:0];
        r_wdata = '0;
        l_wdata = '0;
        t_wdata = '0;
        if (clr_q == TBL_AW'(TBL_DEPTH - 1)) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + tbl_addr_t'(1);
        end
      end
      S_IDLE: begin
        if (accept) begin
          unique case (command_i)
            CMD_FEED: begin
              if (is_letter) begin
                // Window shifts now; the table addresses use the old middle and earlier letters and the new letter.
                earlier_d = middle_q;
                middle_d  = new_letter;
                r_addr_d  = tbl_index(middle_q, new_letter);
                l_addr_d  = tbl_index(middle_q, earlier_q);
                t_addr_d  = TOTAL_AW'(middle_q);
                state_d   = S_COUNT;
              end
            end
            CMD_READ: begin
              pair_ok_d  = q_ok && n_ok;
              total_ok_d = q_ok;
              r_addr_d   = (q_ok && n_ok) ?
                           tbl_index(LETTER_W'(query_letter_i), LETTER_W'(neighbor_letter_i)) :
                           '0;
              l_addr_d   = r_addr_d;
              t_addr_d   = q_ok ? TOTAL_AW'(query_letter_i) : '0;
              state_d    = S_QRD;
            end
            CMD_CLEAR: begin
              earlier_d = '0;
              middle_d  = '0;
              count_d   = '0;
              clr_d     = '0;
              state_d   = S_CLEAR;
            end
            default: begin
            end
          endcase
        end
      end
      S_COUNT: begin
        count_d = inc_res;
        if (inc_res >= count_t'(WINDOW_LEN)) begin
          state_d = S_WR_R;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_WR_R: begin
        r_we    = 1'b1;
        state_d = S_WR_L;
      end
      S_WR_L: begin
        l_we    = 1'b1;
        state_d = S_WR_T;
      end
      S_WR_T: begin
        t_we    = 1'b1;
        state_d = S_IDLE;
      end
      S_QRD: begin
        state_d = S_QOUT;
      end
      S_QOUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      earlier_q   <= '0;
      middle_q    <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      earlier_q   <= earlier_d;
      middle_q    <= middle_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_addr_q   <= r_addr_d;
    l_addr_q   <= l_addr_d;
    t_addr_q   <= t_addr_d;
    pair_ok_q  <= pair_ok_d;
    total_ok_q <= total_ok_d;
    if (out_load) begin
      right_q <= pair_ok_q ? OUT_W'(r_rdata) : '0;
      left_q  <= pair_ok_q ? OUT_W'(l_rdata) : '0;
      total_q <= total_ok_q ? OUT_W'(t_rdata) : '0;
      seen_q  <= OUT_W'(count_q);
    end
  end

  lcc_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(TBL_DEPTH)) u_right_ram (
    .clk_i   (clk_i),
    .we_i    (r_we),
    .waddr_i (r_waddr),
    .wdata_i (r_wdata),
    .raddr_i (r_addr_q),
    .rdata_o (r_rdata)
  );

  lcc_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(TBL_DEPTH)) u_left_ram (
    .clk_i   (clk_i),
    .we_i    (l_we),
    .waddr_i (l_waddr),
    .wdata_i (l_wdata),
    .raddr_i (l_addr_q),
    .rdata_o (l_rdata)
  );

  lcc_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(ALPHABET_SIZE)) u_total_ram (
    .clk_i   (clk_i),
    .we_i    (t_we),
    .waddr_i (t_waddr),
    .wdata_i (t_wdata),
    .raddr_i (t_addr_q),
    .rdata_o (t_rdata)
  );

  assign out_valid_o      = out_valid_q;
  assign right_contacts_o = right_q;
  assign left_contacts_o  = left_q;
  assign letter_total_o   = total_q;
  assign letters_seen_o   = seen_q;

endmodule

// ===== hw/rtl/lcc_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Used for the contact tables and the letter totals; no package dependency.
module lcc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/lcc_checker.sv =====
// Port-level checker for the letter contact counter and its bind statement.
// Depends on lcc_pkg for the command codes and CLEAR_CHECK.
module lcc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [1:0]  command_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] right_contacts_o,
  input logic [31:0] left_contacts_o,
  input logic [31:0] letter_total_o,
  input logic [31:0] letters_seen_o
);
  import lcc_pkg::*;

  logic in_xfer;
  assign in_xfer = in_valid_i && !in_stall_o;

  // A stalled result keeps its valid and its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(right_contacts_o) &&
    $stable(left_contacts_o) && $stable(letter_total_o) && $stable(letters_seen_o))
    else $error("stalled result changed");

  // Reads and clears always occupy the sequencer after their transfer.
  a_busy_after_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (command_i == CMD_READ || command_i == CMD_CLEAR) |=> in_stall_o)
    else $error("input not stalled after read or clear");

  // A clear keeps the sequencer busy while it sweeps the tables.
  a_clear_long: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && command_i == CMD_CLEAR |=> in_stall_o ##CLEAR_CHECK in_stall_o)
    else $error("clear finished too early");

  // A new result only appears right after the sequencer was busy with a read.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a read in progress");

endmodule

bind letter_contact_counter lcc_checker u_lcc_checker (.*);
